>>> sv/y86seq_pkg.sv
// shared constants, types and a helper function of the y86 instruction step block
package y86seq_pkg;

  localparam int MEM_BYTES = 1024;
  localparam int AW = $clog2(MEM_BYTES);
  localparam int PW = AW + 1;

  localparam logic [3:0] SP_INDEX = 4'd4;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [3:0] I_HALT  = 4'h0;
  localparam logic [3:0] I_NOP   = 4'h1;
  localparam logic [3:0] I_CMOV  = 4'h2;
  localparam logic [3:0] I_IRMOV = 4'h3;
  localparam logic [3:0] I_RMMOV = 4'h4;
  localparam logic [3:0] I_MRMOV = 4'h5;
  localparam logic [3:0] I_OPQ   = 4'h6;
  localparam logic [3:0] I_JXX   = 4'h7;
  localparam logic [3:0] I_CALL  = 4'h8;
  localparam logic [3:0] I_RET   = 4'h9;
  localparam logic [3:0] I_PUSH  = 4'hA;
  localparam logic [3:0] I_POP   = 4'hB;

  typedef struct packed {
    logic       kind;
    logic [9:0] load_address;
    logic [7:0] load_byte;
  } in_t;

  typedef struct packed {
    logic [9:0]         pc;
    logic [1:0]         status;
    logic               zero_flag;
    logic               sign_flag;
    logic               overflow_flag;
    logic               reg_written;
    logic [3:0]         reg_index;
    logic signed [63:0] reg_value;
  } out_t;

  typedef enum logic [2:0] {BS_PC, BS_PC1, BS_PC2, BS_ALU, BS_SP} bsel_e;
  typedef enum logic [1:0] {RS_A, RS_B, RS_SP} rsel_e;
  typedef enum logic {WD_VALA, WD_NEXT} wsel_e;
  typedef enum logic [2:0] {RW_B_VALA, RW_B_IMM, RW_B_ALU, RW_A_DAT, RW_SP_ALU} rwsel_e;
  typedef enum logic [1:0] {PS_NEXT, PS_IMM, PS_DAT} psel_e;

  typedef struct packed {
    logic   clr;
    logic   k_clr;
    logic   k_inc;
    logic   start;
    logic   load_wr;
    logic   base_ld;
    bsel_e  base_sel;
    logic   mem_wr;
    logic   op_ld;
    logic   rb_ld;
    logic   sh_imm;
    logic   sh_dat;
    rsel_e  rf_rsel;
    logic   cap_a;
    logic   cap_b;
    logic   cap_sp;
    logic   alu_go;
    logic   wd_ld;
    wsel_e  wd_sel;
    logic   rf_wr;
    rwsel_e rf_wsel;
    logic   cc_ld;
    logic   pc_ld;
    psel_e  pc_sel;
    logic   halt;
    logic   err;
    logic   out_ld;
  } cmd_t;

  typedef struct packed {
    logic [3:0] icode;
    logic [3:0] len;
    logic       running;
    logic       pc_oob;
    logic       len_bad;
    logic       cond_ok;
    logic       fn_ok;
    logic       ea_bad;
    logic       sp_bad;
    logic       push_bad;
    logic       imm_bad;
    logic       dat_bad;
    logic       k_is0;
    logic       k_is7;
    logic       k_is8;
    logic       clr_done;
  } sts_t;

  function automatic logic [3:0] insn_len(input logic [3:0] icode);
    logic [3:0] n;
    unique case (icode)
      I_HALT, I_NOP, I_RET:           n = 4'd1;
      I_CMOV, I_OPQ, I_PUSH, I_POP:   n = 4'd2;
      I_IRMOV, I_RMMOV, I_MRMOV:      n = 4'd10;
      I_JXX, I_CALL:                  n = 4'd9;
      default:                        n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

>>> sv/y86seq_ram.sv
// generic single write port, single read port ram with registered read
module y86seq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> sv/y86seq_ctrl.sv
// sequencer for fetch, operand read, execute and memory access
module y86seq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_kind_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  y86seq_pkg::sts_t   sts_i,
  output y86seq_pkg::cmd_t   cmd_o
);
  import y86seq_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_F0, S_F0W, S_DEC, S_RBW, S_RD, S_RRA, S_RRB, S_RSP, S_RSPW,
    S_ALU, S_EXE, S_WR, S_POST, S_POP2, S_ERR, S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   rd_dat_q, rd_dat_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   c;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = c;

  always_comb begin
    c           = '0;
    state_d     = state_q;
    rd_dat_d    = rd_dat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_CLR: begin
        c.clr   = 1'b1;
        c.k_inc = 1'b1;
        if (sts_i.clr_done) begin
          c.k_clr = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          c.start    = 1'b1;
          c.k_clr    = 1'b1;
          c.base_ld  = 1'b1;
          c.base_sel = BS_PC;
          if (!in_kind_i) begin
            c.load_wr = 1'b1;
            state_d   = S_FIN;
          end else if (!sts_i.running) begin
            state_d = S_FIN;
          end else if (sts_i.pc_oob) begin
            state_d = S_ERR;
          end else begin
            state_d = S_F0;
          end
        end
      end
      S_F0: begin
        c.k_inc = 1'b1;
        state_d = S_F0W;
      end
      S_F0W: begin
        c.op_ld = 1'b1;
        state_d = S_DEC;
      end
      S_DEC: begin
        priority if (sts_i.len_bad) begin
          state_d = S_ERR;
        end else if (sts_i.len == 4'd1) begin
          state_d = S_RRA;
        end else if (sts_i.len == 4'd9) begin
          c.base_ld  = 1'b1;
          c.base_sel = BS_PC1;
          c.k_clr    = 1'b1;
          rd_dat_d   = 1'b0;
          state_d    = S_RD;
        end else begin
          state_d = S_RBW;
        end
      end
      S_RBW: begin
        c.rb_ld = 1'b1;
        if (sts_i.len == 4'd10) begin
          c.base_ld  = 1'b1;
          c.base_sel = BS_PC2;
          c.k_clr    = 1'b1;
          rd_dat_d   = 1'b0;
          state_d    = S_RD;
        end else begin
          state_d = S_RRA;
        end
      end
      S_RD: begin
        c.k_inc  = 1'b1;
        c.sh_imm = !sts_i.k_is0 && !rd_dat_q;
        c.sh_dat = !sts_i.k_is0 && rd_dat_q;
        if (sts_i.k_is8) begin
          state_d = rd_dat_q ? S_POST : S_RRA;
        end
      end
      S_RRA: begin
        c.rf_rsel = RS_A;
        state_d   = S_RRB;
      end
      S_RRB: begin
        c.rf_rsel = RS_B;
        c.cap_a   = 1'b1;
        state_d   = S_RSP;
      end
      S_RSP: begin
        c.rf_rsel = RS_SP;
        c.cap_b   = 1'b1;
        state_d   = S_RSPW;
      end
      S_RSPW: begin
        c.cap_sp = 1'b1;
        state_d  = S_ALU;
      end
      S_ALU: begin
        c.alu_go = 1'b1;
        state_d  = S_EXE;
      end
      S_EXE: begin
        state_d = S_FIN;
        c.pc_sel = PS_NEXT;
        unique case (sts_i.icode)
          I_HALT: c.halt = 1'b1;
          I_NOP:  c.pc_ld = 1'b1;
          I_CMOV: begin
            c.pc_ld   = 1'b1;
            c.rf_wr   = sts_i.cond_ok;
            c.rf_wsel = RW_B_VALA;
          end
          I_IRMOV: begin
            c.pc_ld   = 1'b1;
            c.rf_wr   = 1'b1;
            c.rf_wsel = RW_B_IMM;
          end
          I_RMMOV: begin
            if (sts_i.ea_bad) begin
              state_d = S_ERR;
            end else begin
              c.pc_ld    = 1'b1;
              c.base_ld  = 1'b1;
              c.base_sel = BS_ALU;
              c.wd_ld    = 1'b1;
              c.wd_sel   = WD_VALA;
              c.k_clr    = 1'b1;
              state_d    = S_WR;
            end
          end
          I_MRMOV: begin
            if (sts_i.ea_bad) begin
              state_d = S_ERR;
            end else begin
              c.pc_ld    = 1'b1;
              c.base_ld  = 1'b1;
              c.base_sel = BS_ALU;
              c.k_clr    = 1'b1;
              rd_dat_d   = 1'b1;
              state_d    = S_RD;
            end
          end
          I_OPQ: begin
            c.pc_ld   = 1'b1;
            c.rf_wr   = sts_i.fn_ok;
            c.cc_ld   = sts_i.fn_ok;
            c.rf_wsel = RW_B_ALU;
          end
          I_JXX: begin
            if (sts_i.cond_ok && sts_i.imm_bad) begin
              state_d = S_ERR;
            end else begin
              c.pc_ld  = 1'b1;
              c.pc_sel = sts_i.cond_ok ? PS_IMM : PS_NEXT;
            end
          end
          I_CALL: begin
            if (sts_i.ea_bad || sts_i.imm_bad) begin
              state_d = S_ERR;
            end else begin
              c.rf_wr    = 1'b1;
              c.rf_wsel  = RW_SP_ALU;
              c.base_ld  = 1'b1;
              c.base_sel = BS_ALU;
              c.wd_ld    = 1'b1;
              c.wd_sel   = WD_NEXT;
              c.pc_ld    = 1'b1;
              c.pc_sel   = PS_IMM;
              c.k_clr    = 1'b1;
              state_d    = S_WR;
            end
          end
          I_RET: begin
            if (sts_i.sp_bad) begin
              state_d = S_ERR;
            end else begin
              c.base_ld  = 1'b1;
              c.base_sel = BS_SP;
              c.k_clr    = 1'b1;
              rd_dat_d   = 1'b1;
              state_d    = S_RD;
            end
          end
          I_PUSH: begin
            if (sts_i.push_bad) begin
              state_d = S_ERR;
            end else begin
              c.rf_wr    = 1'b1;
              c.rf_wsel  = RW_SP_ALU;
              c.base_ld  = 1'b1;
              c.base_sel = BS_ALU;
              c.wd_ld    = 1'b1;
              c.wd_sel   = WD_VALA;
              c.pc_ld    = 1'b1;
              c.k_clr    = 1'b1;
              state_d    = S_WR;
            end
          end
          I_POP: begin
            if (sts_i.sp_bad) begin
              state_d = S_ERR;
            end else begin
              c.pc_ld    = 1'b1;
              c.base_ld  = 1'b1;
              c.base_sel = BS_SP;
              c.k_clr    = 1'b1;
              rd_dat_d   = 1'b1;
              state_d    = S_RD;
            end
          end
          default: state_d = S_ERR;
        endcase
      end
      S_WR: begin
        c.mem_wr = 1'b1;
        c.k_inc  = 1'b1;
        if (sts_i.k_is7) begin
          state_d = S_FIN;
        end
      end
      S_POST: begin
        state_d = S_FIN;
        priority if (sts_i.icode == I_RET) begin
          if (sts_i.dat_bad) begin
            state_d = S_ERR;
          end else begin
            c.rf_wr   = 1'b1;
            c.rf_wsel = RW_SP_ALU;
            c.pc_ld   = 1'b1;
            c.pc_sel  = PS_DAT;
          end
        end else if (sts_i.icode == I_POP) begin
          c.rf_wr   = 1'b1;
          c.rf_wsel = RW_SP_ALU;
          state_d   = S_POP2;
        end else begin
          c.rf_wr   = 1'b1;
          c.rf_wsel = RW_A_DAT;
        end
      end
      S_POP2: begin
        // popped value lands after the stack pointer update
        c.rf_wr   = 1'b1;
        c.rf_wsel = RW_A_DAT;
        state_d   = S_FIN;
      end
      S_ERR: begin
        c.err   = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          c.out_ld    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      rd_dat_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_dat_q    <= rd_dat_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_rise_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result raised outside finish state");

  a_port_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(c.mem_wr && (c.load_wr || c.clr)))
    else $error("two writers on the memory port");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("result dropped while the receiver stalls");
endmodule

>>> sv/y86seq_dp.sv
// datapath: architectural state, memories, adder and result register
module y86seq_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  y86seq_pkg::in_t   in_data_i,
  input  y86seq_pkg::cmd_t  cmd_i,
  output y86seq_pkg::sts_t  sts_o,
  output y86seq_pkg::out_t  out_data_o
);
  import y86seq_pkg::*;

  logic [PW-1:0] pc_q;
  logic [1:0]    status_q;
  logic [2:0]    cc_q;
  logic [7:0]    op_q, rbyte_q;
  logic [AW-1:0] base_q, k_q, base_d, mem_addr, mem_waddr;
  logic [63:0]   val_a_q, val_b_q, sp_q, imm_q, dat_q, alu_q, wd_q;
  logic          ovf_q;
  logic          wr_q;
  logic [3:0]    widx_q;
  logic [63:0]   wval_q;
  out_t          out_q;

  logic [7:0]    mem_rdata, mem_wdata;
  logic          mem_we;
  logic [63:0]   rf_rdata, rf_wdata;
  logic [3:0]    rf_raddr, rf_waddr;
  logic          rf_we;

  logic [3:0]    icode, ifun, ra, rb, len;
  logic [PW:0]   len_sum;
  logic [PW-1:0] next_pc, pc_d;
  logic          load_ok, lt, cond;
  logic [63:0]   add_a, add_b, sum, alu_d;
  logic          add_sub, ovf_d;

  function automatic logic span8_ok(input logic [63:0] a);
    return a <= 64'(MEM_BYTES - 8);
  endfunction

  assign icode   = op_q[7:4];
  assign ifun    = op_q[3:0];
  assign ra      = rbyte_q[7:4];
  assign rb      = rbyte_q[3:0];
  assign len     = insn_len(icode);
  assign len_sum = {1'b0, pc_q} + (PW+1)'(len);
  assign next_pc = PW'(len_sum);
  assign load_ok = 32'(in_data_i.load_address) < MEM_BYTES;
  assign mem_addr = base_q + k_q;

  // condition evaluation
  assign lt = cc_q[1] ^ cc_q[2];
  always_comb begin
    unique case (ifun)
      4'd0:    cond = 1'b1;
      4'd1:    cond = lt || cc_q[0];
      4'd2:    cond = lt;
      4'd3:    cond = cc_q[0];
      4'd4:    cond = !cc_q[0];
      4'd5:    cond = !lt;
      4'd6:    cond = !lt && !cc_q[0];
      default: cond = 1'b0;
    endcase
  end

  always_comb begin
    sts_o          = '0;
    sts_o.icode    = icode;
    sts_o.len      = len;
    sts_o.running  = (status_q == ST_RUN);
    sts_o.pc_oob   = pc_q >= PW'(MEM_BYTES);
    sts_o.len_bad  = (len == 4'd0) || (len_sum > (PW+1)'(MEM_BYTES));
    sts_o.cond_ok  = cond;
    sts_o.fn_ok    = ifun <= 4'd3;
    sts_o.ea_bad   = !span8_ok(alu_q);
    sts_o.sp_bad   = !span8_ok(sp_q);
    sts_o.push_bad = alu_q[63] || (alu_q < 64'd8) || !span8_ok(alu_q);
    sts_o.imm_bad  = imm_q[63:AW] != '0;
    sts_o.dat_bad  = dat_q[63:AW] != '0;
    sts_o.k_is0    = k_q == '0;
    sts_o.k_is7    = k_q == AW'(7);
    sts_o.k_is8    = k_q == AW'(8);
    sts_o.clr_done = k_q == AW'(MEM_BYTES - 1);
  end

  // shared adder for alu, address and stack pointer arithmetic
  always_comb begin
    add_a   = sp_q;
    add_b   = 64'd8;
    add_sub = 1'b0;
    unique case (icode)
      I_OPQ: begin
        add_a   = val_b_q;
        add_b   = val_a_q;
        add_sub = (ifun == 4'd1);
      end
      I_RMMOV, I_MRMOV: begin
        add_a = val_b_q;
        add_b = imm_q;
      end
      I_CALL, I_PUSH: add_sub = 1'b1;
      default: add_sub = 1'b0;
    endcase
    sum = add_a + (add_sub ? ~add_b : add_b) + 64'(add_sub);
    alu_d = sum;
    ovf_d = 1'b0;
    if (icode == I_OPQ) begin
      unique case (ifun)
        4'd0:    ovf_d = ~(val_a_q[63] ^ val_b_q[63]) & (val_b_q[63] ^ sum[63]);
        4'd1:    ovf_d = (val_a_q[63] ^ val_b_q[63]) & (val_b_q[63] ^ sum[63]);
        4'd2:    alu_d = val_b_q & val_a_q;
        4'd3:    alu_d = val_b_q ^ val_a_q;
        default: ovf_d = 1'b0;
      endcase
    end
  end

  // memory port selection
  always_comb begin
    mem_we    = cmd_i.clr || cmd_i.mem_wr || (cmd_i.load_wr && load_ok);
    mem_waddr = mem_addr;
    mem_wdata = wd_q[7:0];
    priority if (cmd_i.clr) begin
      mem_waddr = k_q;
      mem_wdata = '0;
    end else if (cmd_i.load_wr) begin
      mem_waddr = AW'(in_data_i.load_address);
      mem_wdata = in_data_i.load_byte;
    end
  end

  // register file port selection
  always_comb begin
    unique case (cmd_i.rf_rsel)
      RS_A:    rf_raddr = ra;
      RS_B:    rf_raddr = rb;
      default: rf_raddr = SP_INDEX;
    endcase
    unique case (cmd_i.rf_wsel)
      RW_B_VALA: begin rf_waddr = rb;       rf_wdata = val_a_q; end
      RW_B_IMM:  begin rf_waddr = rb;       rf_wdata = imm_q;   end
      RW_B_ALU:  begin rf_waddr = rb;       rf_wdata = alu_q;   end
      RW_A_DAT:  begin rf_waddr = ra;       rf_wdata = dat_q;   end
      default:   begin rf_waddr = SP_INDEX; rf_wdata = alu_q;   end
    endcase
    rf_we = cmd_i.rf_wr || cmd_i.clr;
    if (cmd_i.clr) begin
      rf_waddr = k_q[3:0];
      rf_wdata = '0;
    end
  end

  always_comb begin
    unique case (cmd_i.base_sel)
      BS_PC:   base_d = AW'(pc_q);
      BS_PC1:  base_d = AW'(pc_q + PW'(1));
      BS_PC2:  base_d = AW'(pc_q + PW'(2));
      BS_ALU:  base_d = AW'(alu_q);
      default: base_d = AW'(sp_q);
    endcase
    unique case (cmd_i.pc_sel)
      PS_NEXT: pc_d = next_pc;
      PS_IMM:  pc_d = PW'(imm_q);
      default: pc_d = PW'(dat_q);
    endcase
  end

  y86seq_ram #(.Width(8), .Depth(MEM_BYTES)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  y86seq_ram #(.Width(64), .Depth(16)) u_rf (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (rf_raddr),
    .rdata_o (rf_rdata)
  );

  // architectural control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      status_q <= ST_RUN;
      cc_q     <= '0;
      k_q      <= '0;
      wr_q     <= 1'b0;
      widx_q   <= '0;
      wval_q   <= '0;
    end else begin
      if (cmd_i.k_clr) begin
        k_q <= '0;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + AW'(1);
      end
      if (cmd_i.pc_ld) begin
        pc_q <= pc_d;
      end
      if (cmd_i.halt) begin
        status_q <= ST_HALT;
      end else if (cmd_i.err) begin
        status_q <= ST_ERR;
      end
      if (cmd_i.cc_ld) begin
        cc_q <= {ovf_q, alu_q[63], alu_q == '0};
      end
      if (cmd_i.start || cmd_i.err) begin
        wr_q   <= 1'b0;
        widx_q <= '0;
        wval_q <= '0;
      end else if (cmd_i.rf_wr) begin
        wr_q   <= 1'b1;
        widx_q <= rf_waddr;
        wval_q <= rf_wdata;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.base_ld) base_q  <= base_d;
    if (cmd_i.op_ld)   op_q    <= mem_rdata;
    if (cmd_i.rb_ld)   rbyte_q <= mem_rdata;
    if (cmd_i.start)   rbyte_q <= '0;
    if (cmd_i.sh_imm)  imm_q   <= {mem_rdata, imm_q[63:8]};
    if (cmd_i.start)   imm_q   <= '0;
    if (cmd_i.sh_dat)  dat_q   <= {mem_rdata, dat_q[63:8]};
    if (cmd_i.cap_a)   val_a_q <= rf_rdata;
    if (cmd_i.cap_b)   val_b_q <= rf_rdata;
    if (cmd_i.cap_sp)  sp_q    <= rf_rdata;
    if (cmd_i.alu_go) begin
      alu_q <= alu_d;
      ovf_q <= ovf_d;
    end
    if (cmd_i.wd_ld) begin
      wd_q <= (cmd_i.wd_sel == WD_NEXT) ? 64'(next_pc) : val_a_q;
    end else if (cmd_i.mem_wr) begin
      wd_q <= {8'h00, wd_q[63:8]};
    end
    if (cmd_i.out_ld) begin
      out_q.pc            <= 10'(pc_q);
      out_q.status        <= status_q;
      out_q.zero_flag     <= cc_q[0];
      out_q.sign_flag     <= cc_q[1];
      out_q.overflow_flag <= cc_q[2];
      out_q.reg_written   <= wr_q;
      out_q.reg_index     <= widx_q;
      out_q.reg_value     <= wval_q;
    end
  end

  assign out_data_o = out_q;

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PW'(MEM_BYTES))
    else $error("program counter beyond memory");

  a_stopped_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_q != ST_RUN) |=> $stable(pc_q))
    else $error("program counter moved while stopped");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q != 2'd3)
    else $error("invalid run status");
endmodule

>>> sv/y86_sequential_instruction_step_top.sv
// top level of the sequential y86 instruction step block
//
// input channel (in_valid_i / in_ready_o / in_data_i): one transfer is either a
// load item that writes one program byte, or a step item that runs one
// instruction at the program counter
// output channel (out_valid_o / out_ready_i / out_data_o): one transfer per
// input item with the pc, run status, condition codes and register write
// a load item, or a step while halted or in error, goes from idle straight to
// the finish state; a step item is longer, since every fetch and data byte
// goes through the byte-wide memory, one a cycle, and the register file
// operands ra, rb and the stack pointer are read one after another
// one item is worked on at a time; in_ready_o rises again in the cycle the
// result is placed in the output register
// after reset the memory and register file are swept to zero with in_ready_o
// low; pc, status and condition codes reset to zero
// a stalled receiver holds the result in the output register and the block
// waits before finishing the next item
module y86_sequential_instruction_step_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  y86seq_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output y86seq_pkg::out_t  out_data_o
);
  import y86seq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  y86seq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_data_i.kind),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // state, memories and arithmetic
  y86seq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );
endmodule
